>>> src/rgse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream - shared definitions
// Field widths, register codes, reset values, gray weights and the per-pixel
// flag group that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rgse_pkg;

  localparam int PIX_W   = 8;   // one color channel, one gray pixel
  localparam int CFG_W   = 12;  // configuration register width
  localparam int CFG_IDX_W = 1; // two registers
  localparam int PROD_W  = 24;  // weighted channel product / weighted sum

  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 2048;
  localparam int QUEUE_DEPTH        = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  // BT.709 luma weights in unsigned Q0.16; they sum to exactly 65536.
  localparam logic [15:0] WEIGHT_RED   = 16'd13933;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  // What the back end must do with a pixel once it has updated its window.
  typedef struct packed {
    logic emit;    // centre (r-1,c-1) produces a result
    logic border;  // centre lies in the first row or first column
    logic last;    // centre is the last one of the frame
  } pix_flags_t;

  localparam int FLAGS_W = $bits(pix_flags_t);

endpackage

>>> src/rgse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream - front end
// Holds the geometry registers, tracks the raster position of each accepted
// pixel, classifies it and converts it to gray before it enters the queue.
// ----------------------------------------------------------------------------
module rgse_front import rgse_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  input  logic                 frame_start,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [PIX_W-1:0]     q_gray,
  output logic [CW-1:0]        q_col,
  output pix_flags_t           q_flags
);

  // Wide enough to hold the saturated geometry itself.
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;

  logic [WW-1:0] col_w, c_pos, c_inc, col_next;
  logic [HW-1:0] row_h, r_pos, r_inc, row_next;
  logic          wrap_pre;
  pix_flags_t    flags;

  logic              accept;
  logic              f1_valid;
  logic [PROD_W-1:0] f1_pr, f1_pg, f1_pb;
  logic [PROD_W-1:0] gray_sum;
  logic [CW-1:0]     f1_col;
  pix_flags_t        f1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry saturated to 3..MAX.
  always_comb begin
    if (image_width < 12'd3) begin
      w_eff = WW'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < 12'd3) begin
      h_eff = HW'(3);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // Position of this pixel, then the position of the next one.
  always_comb begin
    col_w    = WW'(col_cnt);
    row_h    = HW'(row_cnt);
    wrap_pre = (col_w >= w_eff);
    r_pos    = wrap_pre ? row_h + HW'(1) : row_h;
    if (r_pos >= h_eff) begin
      r_pos = '0;
    end
    c_pos = wrap_pre ? '0 : col_w;
    if (frame_start) begin
      r_pos = '0;
      c_pos = '0;
    end

    c_inc = c_pos + WW'(1);
    r_inc = r_pos + HW'(1);
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc;
    end else begin
      col_next = c_inc;
      row_next = r_pos;
    end

    flags.emit   = (r_pos != '0) && (c_pos != '0);
    flags.border = (r_pos == HW'(1)) || (c_pos == WW'(1));
    flags.last   = (r_pos == h_eff - HW'(1)) && (c_pos == w_eff - WW'(1));
  end

  assign in_ready = !f1_valid || q_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      f1_valid <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt  <= CW'(col_next);
        row_cnt  <= RW'(row_next);
        f1_valid <= 1'b1;
      end else if (q_ready) begin
        f1_valid <= 1'b0;
      end
    end
  end

  // Weighted channels are registered; their sum feeds the queue.
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pr    <= PROD_W'(red)   * PROD_W'(WEIGHT_RED);
      f1_pg    <= PROD_W'(green) * PROD_W'(WEIGHT_GREEN);
      f1_pb    <= PROD_W'(blue)  * PROD_W'(WEIGHT_BLUE);
      f1_col   <= CW'(c_pos);
      f1_flags <= flags;
    end
  end

  assign gray_sum = f1_pr + f1_pg + f1_pb;
  assign q_valid  = f1_valid;
  assign q_gray   = gray_sum[PROD_W-1:PROD_W-PIX_W];
  assign q_col    = f1_col;
  assign q_flags  = f1_flags;

endmodule

>>> src/rgse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream - pixel queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rgse_queue import rgse_pkg::*; #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [NW-1:0]     count;
  logic              push, pop;

  assign in_ready  = (count != NW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

>>> src/rgse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream - back end
// Line memories, 3x3 window, Sobel sum with clamping and the output register.
// ----------------------------------------------------------------------------
module rgse_back import rgse_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [PIX_W-1:0] q_gray,
  input  logic [CW-1:0]    q_col,
  input  pix_flags_t       q_flags,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] edge_value,
  output logic             at_border,
  output logic             frame_last
);

  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];  // previous row
  logic [PIX_W-1:0] mem_top [MAX_WIDTH];  // row before that

  logic adv;

  logic             b1_valid;
  logic [CW-1:0]    b1_col;
  logic [PIX_W-1:0] b1_gray;
  pix_flags_t       b1_flags;
  logic [PIX_W-1:0] rd_mid, rd_top;
  logic             b1_fwd;
  logic [PIX_W-1:0] fwd_mid, fwd_top;
  logic [PIX_W-1:0] b1_mid_sel, b1_top_sel;

  logic [PIX_W-1:0] win [3][3];

  logic             b2_valid;
  pix_flags_t       b2_flags;

  logic [PIX_W+1:0]   pos_sum, neg_sum;
  logic signed [PIX_W+2:0] diff;
  logic [PIX_W-1:0]   edge_clamped;

  // The whole back end moves together whenever the output register can load.
  assign adv   = !out_valid || out_ready;
  assign q_pop = q_valid && adv;

  // A pixel that reads the column written by the pixel just ahead of it
  // takes the written values instead of the stale memory data.
  assign b1_mid_sel = b1_fwd ? fwd_mid : rd_mid;
  assign b1_top_sel = b1_fwd ? fwd_top : rd_top;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_valid) begin
        rd_mid <= mem_mid[q_col];
        rd_top <= mem_top[q_col];
      end
      if (b1_valid) begin
        mem_mid[b1_col] <= b1_gray;
        mem_top[b1_col] <= b1_mid_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= q_valid;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid && b2_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_col   <= q_col;
      b1_gray  <= q_gray;
      b1_flags <= q_flags;
      b1_fwd   <= b1_valid && q_valid && (b1_col == q_col);
      fwd_mid  <= b1_gray;
      fwd_top  <= b1_mid_sel;
      b2_flags <= b1_flags;
      if (b1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= b1_top_sel;
        win[1][2] <= b1_mid_sel;
        win[2][2] <= b1_gray;
      end
      if (b2_valid && b2_flags.emit) begin
        edge_value <= b2_flags.border ? '0 : edge_clamped;
        at_border  <= b2_flags.border;
        frame_last <= b2_flags.last;
      end
    end
  end

  // Combined kernel is twice (top-left three minus bottom-right three).
  always_comb begin
    pos_sum = (PIX_W+2)'(win[0][0]) + (PIX_W+2)'(win[0][1]) + (PIX_W+2)'(win[1][0]);
    neg_sum = (PIX_W+2)'(win[1][2]) + (PIX_W+2)'(win[2][1]) + (PIX_W+2)'(win[2][2]);
    diff    = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
    if (diff[PIX_W+2]) begin
      edge_clamped = '0;
    end else if (diff > (PIX_W+3)'(127)) begin
      edge_clamped = EDGE_MAX;
    end else begin
      edge_clamped = {diff[PIX_W-2:0], 1'b0};
    end
  end

endmodule

>>> src/rgb_gray_sobel_edge_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream unit - top level
// Converts a raster stream of RGB pixels to gray and produces a clamped
// 3x3 Sobel edge value for each interior centre pixel.
// ----------------------------------------------------------------------------
// The unit takes one RGB pixel per clock in raster order while in_ready is
// high and returns at most one result per pixel: the pixel at (row r, column
// c) produces the result for centre (r-1, c-1), so pixels in row 0 or column
// 0 produce nothing and the last row and column are never centres. Sustained
// throughput is one pixel per clock while the output side takes results;
// that figure is set by the two line memories, each of which is read once
// and written once per pixel. A pixel's result passes the input stage, queue,
// memory read, window update and output register, and is held back when the
// output side stalls. The input side keeps taking requests while a result
// waits, until the four-entry queue and the input stage are both full. A
// frame_start request restarts the position at (0,0); the frame also wraps
// by itself after its last pixel. Width and height must be written through
// the configuration port only while the stream is idle; the block does not
// enforce this. They are saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT. The
// line memories need no clearing pass after reset; their contents are only
// defined once two full rows have passed at the current width.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_stream_unit import rgse_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes.
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Pixel requests.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  input  logic                 frame_start,
  // Edge results.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     edge_value,
  output logic                 at_border,
  output logic                 frame_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int ITEM_W = PIX_W + CW + FLAGS_W;

  // Front end to queue.
  logic             f_valid;
  logic             f_ready;
  logic [PIX_W-1:0] f_gray;
  logic [CW-1:0]    f_col;
  pix_flags_t       f_flags;

  // Queue to back end.
  logic              b_valid;
  logic              b_pop;
  logic [ITEM_W-1:0] b_item;
  logic [PIX_W-1:0]  b_gray;
  logic [CW-1:0]     b_col;
  pix_flags_t        b_flags;

  // The front end owns the geometry and the position counters; each pixel
  // leaves it as a gray value tagged with its column and what to emit.
  rgse_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_gray      (f_gray),
    .q_col       (f_col),
    .q_flags     (f_flags)
  );

  // The queue lets the front end keep accepting while the back end waits on
  // the output side.
  rgse_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_gray, f_col, f_flags}),
    .out_valid (b_valid),
    .out_ready (b_pop),
    .out_data  (b_item)
  );

  assign {b_gray, b_col, b_flags} = b_item;

  // The back end updates the line memories and the window for every pixel
  // and loads the output register for pixels that produce a result.
  rgse_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_pop      (b_pop),
    .q_gray     (b_gray),
    .q_col      (b_col),
    .q_flags    (b_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_value (edge_value),
    .at_border  (at_border),
    .frame_last (frame_last)
  );

endmodule

>>> test/rgb_gray_sobel_edge_stream_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB gray Sobel edge stream unit - self-checking testbench
// Streams RGB pixel requests through the unit under a series of frame
// geometries and handshake idling patterns. A behavioral predictor in this
// bench converts each accepted pixel to gray, keeps its own line rows and 3x3
// window, and queues the edge result that the unit must return. Every
// returned result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_stream_unit_test;
  import rgse_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  // A safe margin for pixels that produce no result but are still in flight
  // after the last result has come back.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Pixel styles for the random stream: full-range noise, saturated
  // channels, and a slowly drifting gray that keeps edge sums small.
  typedef enum {STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH} pixel_style_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             at_border;
    logic             frame_last;
  } edge_result_t;

  // Clock, reset and all block inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     red = '0;
  logic [PIX_W-1:0]     green = '0;
  logic [PIX_W-1:0]     blue = '0;
  logic                 frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     edge_value;
  logic                 at_border;
  logic                 frame_last;

  // Pixel requests waiting for the driver, and edge results still owed.
  pixel_req_t   pending_pixels[$];
  edge_result_t expected_edges[$];

  // Handshake idling, in percent of cycles.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state: register copies, the two line rows, the window and the
  // raster position of the next pixel.
  logic [CFG_W-1:0] shadow_width = IMAGE_WIDTH_RESET;
  logic [CFG_W-1:0] shadow_height = IMAGE_HEIGHT_RESET;
  logic [PIX_W-1:0] older_row [MAX_W];
  logic [PIX_W-1:0] newer_row [MAX_W];
  logic [PIX_W-1:0] gray_window [3][3];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  // Drifting gray level for the smooth pixel style.
  int smooth_level = 128;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned settings_written = 0;

  rgb_gray_sobel_edge_stream_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_value (edge_value),
    .at_border  (at_border),
    .frame_last (frame_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        gray_window[i][j] = '0;
      end
    end
  end

  // Frame dimensions as the unit uses them: saturated to 3..limit.
  function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned limit);
    if (value < 3) return 3;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic logic [PIX_W-1:0] clip8(input int value);
    if (value < 0) return '0;
    if (value > 255) return 8'd255;
    return PIX_W'(value);
  endfunction

  function automatic pixel_req_t make_pixel(input int r, input int g, input int b,
                                            input logic fs);
    pixel_req_t px;
    px.red = PIX_W'(r);
    px.green = PIX_W'(g);
    px.blue = PIX_W'(b);
    px.frame_start = fs;
    return px;
  endfunction

  // Advances the predictor by one accepted pixel and queues the edge result
  // it causes, if any. The pixel at (r,c) yields the result for centre
  // (r-1,c-1); first-row and first-column centres are border results.
  task automatic predict_pixel(input pixel_req_t px);
    int unsigned  w_eff;
    int unsigned  h_eff;
    int unsigned  r;
    int unsigned  c;
    int unsigned  luma_acc;
    int           sobel_sum;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    edge_result_t res;
    w_eff = clamp_dim(shadow_width, MAX_W);
    h_eff = clamp_dim(shadow_height, MAX_H);
    // A shrunken geometry can leave the position past the row or the frame.
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h_eff) row_pos = 0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;

    // BT.709 luma in Q0.16, truncated.
    luma_acc = 13933 * px.red + 46871 * px.green + 4732 * px.blue;
    gray = PIX_W'(luma_acc >> 16);

    top = older_row[c];
    mid = newer_row[c];
    older_row[c] = mid;
    newer_row[c] = gray;

    for (int i = 0; i < 3; i++) begin
      gray_window[i][0] = gray_window[i][1];
      gray_window[i][1] = gray_window[i][2];
    end
    gray_window[0][2] = top;
    gray_window[1][2] = mid;
    gray_window[2][2] = gray;

    if (r >= 1 && c >= 1) begin
      // The x and y kernels fold into one: top-left weights of +2 and
      // bottom-right weights of -2, with the anti-diagonal at zero.
      sobel_sum = 2 * int'(gray_window[0][0]) + 2 * int'(gray_window[0][1])
                + 2 * int'(gray_window[1][0]) - 2 * int'(gray_window[1][2])
                - 2 * int'(gray_window[2][1]) - 2 * int'(gray_window[2][2]);
      res.at_border = (r == 1 || c == 1);
      res.edge_value = res.at_border ? '0 : clip8(sobel_sum);
      res.frame_last = (r == h_eff - 1 && c == w_eff - 1);
      expected_edges.push_back(res);
    end

    col_pos = c + 1;
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h_eff) row_pos = 0;
    end
  endtask

  // Driver: offers the next pending request whenever the channel is free,
  // with random gaps, and toggles out_ready according to the stall rate.
  // A request stays on the bus unchanged until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          pixel_req_t next_px;
          next_px = pending_pixels.pop_front();
          in_valid <= 1'b1;
          red <= next_px.red;
          green <= next_px.green;
          blue <= next_px.blue;
          frame_start <= next_px.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on every accepted request, then checks every accepted
  // result. Both happen in this one block so that a prediction is always in
  // place before the result it belongs to is looked at.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_pixel(make_pixel(red, green, blue, frame_start));
        pixels_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("Unexpected result: edge_value %0d at_border %0b frame_last %0b",
                     edge_value, at_border, frame_last);
          end
          mismatch_count++;
        end else begin
          edge_result_t want;
          want = expected_edges.pop_front();
          results_checked++;
          if (edge_value !== want.edge_value || at_border !== want.at_border ||
              frame_last !== want.frame_last) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("Result %0d differs: edge_value %0d/%0d at_border %0b/%0b %s",
                       results_checked, want.edge_value, edge_value, want.at_border,
                       at_border, $sformatf("frame_last %0b/%0b (expected/actual)",
                       want.frame_last, frame_last));
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               expected_edges.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 70;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        recv_stall_pct = 70;
      end
      default: begin
        send_gap_pct = 11;
        recv_stall_pct = 11;
      end
    endcase
  endtask

  // Holds off until every request has gone in and every result has come
  // back, then lets the pipeline empty of pixels that produce nothing.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both geometry registers on back-to-back cycles; only called while
  // the unit is idle.
  task automatic write_registers(input logic [CFG_W-1:0] width_val,
                                 input logic [CFG_W-1:0] height_val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= width_val;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= height_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_width = width_val;
    shadow_height = height_val;
    settings_written++;
    @(negedge clk);
  endtask

  function automatic pixel_req_t random_pixel(input pixel_style_e style, input logic fs);
    case (style)
      STYLE_NOISE: begin
        return make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), fs);
      end
      STYLE_EXTREME: begin
        return make_pixel({8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                          {8{1'($urandom_range(1))}}, fs);
      end
      default: begin
        smooth_level = clip8(smooth_level + int'($urandom_range(8)) - 4);
        return make_pixel(clip8(smooth_level + int'($urandom_range(4)) - 2),
                          clip8(smooth_level + int'($urandom_range(4)) - 2),
                          clip8(smooth_level + int'($urandom_range(4)) - 2), fs);
      end
    endcase
  endfunction

  // Queues a raster stream. Frames mostly wrap on their own; a noisy stream
  // also restarts the frame at random points.
  task automatic queue_stream(input int count, input logic first_fs, input bit noisy);
    pixel_style_e style;
    logic         fs;
    style = pixel_style_e'($urandom_range(2));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(31) == 0) style = pixel_style_e'($urandom_range(2));
      fs = (i == 0) ? first_fs : (noisy && $urandom_range(127) == 0);
      pending_pixels.push_back(random_pixel(style, fs));
    end
  endtask

  // One test phase: drain, reprogram, pick the idling pattern, queue pixels.
  // Line rows are only valid up to the width in force, so a wider geometry
  // always starts on a fresh frame; a narrower or equal one may continue
  // mid-frame, which can push the position past the new row or frame end.
  task automatic run_phase(input logic [CFG_W-1:0] width_val, input logic [CFG_W-1:0] height_val,
                           input idle_mode_e mode, input int count, input bit noisy);
    logic first_fs;
    wait_drained();
    first_fs = (clamp_dim(width_val, MAX_W) > clamp_dim(shadow_width, MAX_W))
               ? 1'b1 : 1'($urandom_range(1));
    write_registers(width_val, height_val);
    set_idle(mode);
    queue_stream(count, first_fs, noisy);
  endtask

  // A 3x3 frame of black and white pixels, raster order, MSB first.
  task automatic queue_mask_frame(input logic [8:0] mask, input logic fs);
    for (int i = 0; i < 9; i++) begin
      pending_pixels.push_back(mask[8 - i] ? make_pixel(255, 255, 255, (i == 0) && fs)
                                           : make_pixel(0, 0, 0, (i == 0) && fs));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Register values below the minimum saturate to a 3x3
    // frame, so every result is a border result except the last centre.
    write_registers(CFG_W'(0), CFG_W'(1));
    set_idle(IDLE_NONE);
    // Channel extremes; rows 0 and column 0 give nothing.
    pending_pixels.push_back(make_pixel(255, 255, 255, 1'b1));
    pending_pixels.push_back(make_pixel(255, 0, 0, 1'b0));
    pending_pixels.push_back(make_pixel(0, 255, 0, 1'b0));
    pending_pixels.push_back(make_pixel(0, 0, 255, 1'b0));
    pending_pixels.push_back(make_pixel(0, 0, 0, 1'b0));
    pending_pixels.push_back(make_pixel(255, 255, 0, 1'b0));
    pending_pixels.push_back(make_pixel(0, 255, 255, 1'b0));
    pending_pixels.push_back(make_pixel(255, 0, 255, 1'b0));
    pending_pixels.push_back(make_pixel(128, 127, 1, 1'b0));
    // The frame wraps without a frame start: bright top-left clamps high.
    queue_mask_frame(9'b110_100_000, 1'b0);
    // Restarted frame, bright bottom-right: the sum goes negative, clamps low.
    queue_mask_frame(9'b001_011_111, 1'b1);

    // Random part: small geometries, every idling pattern twice, values
    // under the minimum now and then.
    for (int phase = 0; phase < 8; phase++) begin
      run_phase(($urandom_range(5) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 10)),
                ($urandom_range(5) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 6)),
                idle_mode_e'(phase % 4), 60, 1'b1);
    end

    // Largest register values, run briefly: a saturated row width on its
    // first row, and saturated frame heights on narrow frames.
    run_phase(CFG_W'(4095), CFG_W'(0), IDLE_BOTH, 24, 1'b0);
    run_phase(CFG_W'(3), CFG_W'(MAX_H), IDLE_SENDER, 30, 1'b0);
    run_phase(CFG_W'(1), CFG_W'(4095), IDLE_RECEIVER, 30, 1'b0);

    wait_drained();
    $display("Covered %0d pixel requests and %0d edge results over %0d geometry settings,",
             pixels_accepted, results_checked, settings_written);
    $display("from saturated 3x3 frames to saturated row widths and frame heights.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d results were wrong or unexpected.", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
